/* sv/box_blur_3x3_edge_clipped_defines.svh */
// Assertion macros shared by the checker of the 3x3 box blur.
`ifndef BOX_BLUR_3X3_EDGE_CLIPPED_DEFINES_SVH
`define BOX_BLUR_3X3_EDGE_CLIPPED_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define BB3_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bb3 check failed");

// Next-cycle implication, disabled while reset is high.
`define BB3_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bb3 check failed");

`endif

/* sv/bb3_pkg.sv */
// Shared types and constants of the 3x3 box blur.
`default_nettype none
package bb3_pkg;
   localparam int DEF_MAX_WIDTH = 2048;

   // Register indexes of the configuration port.
   localparam logic CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic CSR_IMAGE_HEIGHT = 1'b1;

   // Rounded mean numerator (2*sum+count) and denominator (2*count).
   localparam int NUM_W = 13;
   localparam int DEN_W = 5;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;
endpackage
`default_nettype wire

/* sv/bb3_line_mem.sv */
// Line store: four row slots in one synchronous memory with registered read data.
`default_nettype none
module bb3_line_mem import bb3_pkg::*; #(
   parameter int AW = 11
) (
   input  wire logic            clock,
   input  wire logic            wr_en,
   input  wire logic [AW+1:0]   wr_addr,
   input  wire pixel_type       wr_data,
   input  wire logic [AW+1:0]   rd_addr,
   output pixel_type            rd_data
);
   pixel_type mem [0:(4 << AW)-1];
   pixel_type rd_data_ff;

   // One write and one read port; read data is registered and appears in the next cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

/* sv/bb3_div.sv */
// Restoring divider, one quotient bit per cycle, for the rounded mean.
`default_nettype none
module bb3_div import bb3_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] numer,
   input  wire logic [DEN_W-1:0] denom,
   output logic                  busy,
   output logic [NUM_W-1:0]      quotient
);
   localparam int SW = $clog2(NUM_W + 1);

   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [SW-1:0]    step_ff, step_in;
   logic             busy_ff, busy_in;
   logic [DEN_W:0]   trial;

   // Shift one numerator bit into the remainder and try a subtraction.
   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      trial   = {rem_ff, quo_ff[NUM_W-1]};
      if (start) begin
         rem_in  = '0;
         quo_in  = numer;
         den_in  = denom;
         step_in = SW'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = DEN_W'(trial - {1'b0, den_ff});
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DEN_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
         step_in = step_ff - SW'(1);
         busy_in = (step_ff != SW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;
endmodule
`default_nettype wire

/* sv/box_blur_3x3_edge_clipped.sv */
// Top level of the streaming 3x3 box blur with clipped image edges.
//
// Pixels enter in raster order on the req_ channel; each transfer carries one
// pixel, or a flush item (req_command high) once the frame's pixels are in.
// After width+1 items the block starts giving one blurred pixel per item on
// the rsp_ channel, and width+1 flush items after the last pixel drain the
// frame; the final result has rsp_frame_last set. Frame geometry is taken from
// the csr_ registers when the first item of a frame is accepted.
// Each item that yields a result runs through the sequencer: ST_READ reads the
// neighbors from the line store (one neighbor per cycle through the single read
// port), ST_DRAIN takes the last read, ST_LOAD starts the restoring divider, and
// ST_DIV waits for its 13 quotient bits and a free output register. Only in
// ST_IDLE is the next item accepted, so no item is taken while one is in work.
// Items that yield no result leave the sequencer in ST_IDLE.
// The result sits in an output register; the next item is accepted while it
// waits, and a new result waits in the divider while the receiver stalls.
// Synchronous reset clears stream counters and handshakes; the line store is not
// cleared, as no neighbor is read before it has been written in the frame.
`default_nettype none
module box_blur_3x3_edge_clipped import bb3_pkg::*; #(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_command,
   input  wire logic [7:0]  req_in_red,
   input  wire logic [7:0]  req_in_green,
   input  wire logic [7:0]  req_in_blue,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_out_red,
   output logic [7:0]       rsp_out_green,
   output logic [7:0]       rsp_out_blue,
   output logic             rsp_frame_last,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_wdata
);
   localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int WW = $clog2(MAX_WIDTH + 1) + 1;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_READ  = 5'b00010,
      ST_DRAIN = 5'b00100,
      ST_LOAD  = 5'b01000,
      ST_DIV   = 5'b10000
   } state_type;

   state_type     state_ff, state_in;
   logic [11:0]   img_w_ff;
   logic [15:0]   img_h_ff;
   logic [WW-1:0] frame_w_ff, frame_w_in;
   logic [15:0]   frame_h_ff, frame_h_in;
   logic [WW-1:0] col_ff, col_in;
   logic [16:0]   row_ff, row_in;
   logic [15:0]   orow_ff, orow_in;
   logic [WW-1:0] ocol_ff, ocol_in;
   logic [15:0]   cur_r_ff, cur_r_in;
   logic [WW-1:0] cur_c_ff, cur_c_in;
   logic          last_ff, last_in;
   logic [1:0]    kr_ff, kr_in, kc_ff, kc_in;
   logic          pend_ff;
   logic [11:0]   sum_r_ff, sum_g_ff, sum_b_ff;
   logic [3:0]    cnt_ff;
   logic          rsp_valid_ff;
   logic [7:0]    rsp_r_ff, rsp_g_ff, rsp_b_ff;
   logic          rsp_last_ff;

   logic          accept, first, in_frame, ignore, emit, wr_en, nb_ok, load;
   logic [WW-1:0] fw, fh_w_unused_guard;
   logic [15:0]   fh;
   logic [31:0]   w_ext;
   logic [WW-1:0] col_next;
   logic [1:0]    nb_slot;
   logic [WW-1:0] nb_col;
   pixel_type     wr_pix, rd_pix;
   logic          div_busy_r, div_busy_g, div_busy_b;
   logic [NUM_W-1:0] q_r, q_g, q_b;
   logic [DEN_W-1:0] denom;

   assign fh_w_unused_guard = '0;

   // Configuration register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         img_w_ff <= 12'd1;
         img_h_ff <= 16'd1;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  img_w_ff <= csr_wdata[11:0];
            CSR_IMAGE_HEIGHT: img_h_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Frame geometry, clamped, as seen by the item being accepted.
   always_comb begin
      w_ext = {20'd0, img_w_ff};
      first = (row_ff == 17'd0) && (col_ff == fh_w_unused_guard);
      fw    = frame_w_ff;
      fh    = frame_h_ff;
      if (first) begin
         if (w_ext == 32'd0) begin
            fw = WW'(1);
         end else if (w_ext > 32'(MAX_WIDTH)) begin
            fw = WW'(MAX_WIDTH);
         end else begin
            fw = WW'(w_ext);
         end
         fh = (img_h_ff == 16'd0) ? 16'd1 : img_h_ff;
      end
   end

   assign accept   = req_valid && req_ready;
   assign in_frame = row_ff < {1'b0, fh};
   assign ignore   = in_frame && req_command;
   assign emit     = !ignore && !((row_ff == 17'd0) ||
                     ((row_ff == 17'd1) && (col_ff == '0)));
   assign wr_en    = accept && in_frame && !req_command;
   assign col_next = col_ff + WW'(1);
   assign wr_pix   = '{red: req_in_red, green: req_in_green, blue: req_in_blue};

   // Neighbor address for the current read step, with edge clipping.
   always_comb begin
      nb_ok = !((kr_ff == 2'd0) && (cur_r_ff == 16'd0)) &&
              !((kr_ff == 2'd2) && (cur_r_ff == frame_h_ff - 16'd1)) &&
              !((kc_ff == 2'd0) && (cur_c_ff == '0)) &&
              !((kc_ff == 2'd2) && (cur_c_ff == frame_w_ff - WW'(1)));
      nb_slot = cur_r_ff[1:0] + kr_ff - 2'd1;
      nb_col  = cur_c_ff + WW'(kc_ff) - WW'(1);
   end

   bb3_line_mem #(.AW(AW)) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr ({row_ff[1:0], col_ff[AW-1:0]}),
      .wr_data (wr_pix),
      .rd_addr ({nb_slot, nb_col[AW-1:0]}),
      .rd_data (rd_pix)
   );

   assign load = (state_ff == ST_DIV) && !div_busy_r &&
                 (!rsp_valid_ff || rsp_ready);

   // Sequencer and stream position counters.
   always_comb begin
      state_in   = state_ff;
      frame_w_in = frame_w_ff;
      frame_h_in = frame_h_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      orow_in    = orow_ff;
      ocol_in    = ocol_ff;
      cur_r_in   = cur_r_ff;
      cur_c_in   = cur_c_ff;
      last_in    = last_ff;
      kr_in      = kr_ff;
      kc_in      = kc_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               frame_w_in = fw;
               frame_h_in = fh;
               if (!ignore) begin
                  if (col_next >= fw) begin
                     col_in = '0;
                     row_in = row_ff + 17'd1;
                  end else begin
                     col_in = col_next;
                  end
               end
               if (emit) begin
                  cur_r_in = orow_ff;
                  cur_c_in = ocol_ff;
                  last_in  = (orow_ff == fh - 16'd1) && (ocol_ff == fw - WW'(1));
                  kr_in    = 2'd0;
                  kc_in    = 2'd0;
                  state_in = ST_READ;
                  if ((orow_ff == fh - 16'd1) && (ocol_ff == fw - WW'(1))) begin
                     row_in  = 17'd0;
                     col_in  = '0;
                     orow_in = 16'd0;
                     ocol_in = '0;
                  end else if (ocol_ff + WW'(1) >= fw) begin
                     ocol_in = '0;
                     orow_in = orow_ff + 16'd1;
                  end else begin
                     ocol_in = ocol_ff + WW'(1);
                  end
               end
            end
         end
         ST_READ: begin
            if (kc_ff == 2'd2) begin
               kc_in = 2'd0;
               kr_in = kr_ff + 2'd1;
               if (kr_ff == 2'd2) begin
                  state_in = ST_DRAIN;
               end
            end else begin
               kc_in = kc_ff + 2'd1;
            end
         end
         ST_DRAIN: state_in = ST_LOAD;
         ST_LOAD:  state_in = ST_DIV;
         ST_DIV: begin
            if (load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         frame_w_ff <= WW'(1);
         frame_h_ff <= 16'd1;
         col_ff     <= '0;
         row_ff     <= 17'd0;
         orow_ff    <= 16'd0;
         ocol_ff    <= '0;
         pend_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         frame_w_ff <= frame_w_in;
         frame_h_ff <= frame_h_in;
         col_ff     <= col_in;
         row_ff     <= row_in;
         orow_ff    <= orow_in;
         ocol_ff    <= ocol_in;
         pend_ff    <= (state_ff == ST_READ) && nb_ok;
      end
      cur_r_ff <= cur_r_in;
      cur_c_ff <= cur_c_in;
      last_ff  <= last_in;
      kr_ff    <= kr_in;
      kc_ff    <= kc_in;
   end

   // Neighborhood sums, one neighbor added per returning read inside the image.
   always_ff @(posedge clock) begin
      if (accept) begin
         sum_r_ff <= 12'd0;
         sum_g_ff <= 12'd0;
         sum_b_ff <= 12'd0;
         cnt_ff   <= 4'd0;
      end else if (pend_ff) begin
         sum_r_ff <= sum_r_ff + {4'd0, rd_pix.red};
         sum_g_ff <= sum_g_ff + {4'd0, rd_pix.green};
         sum_b_ff <= sum_b_ff + {4'd0, rd_pix.blue};
         cnt_ff   <= cnt_ff + 4'd1;
      end
   end

   // Rounded mean: (2*sum + count) / (2*count) per channel.
   assign denom = {cnt_ff, 1'b0};

   bb3_div u_div_r (
      .clock (clock), .reset (reset), .start (state_ff == ST_LOAD),
      .numer ({sum_r_ff, 1'b0} + {9'd0, cnt_ff}), .denom (denom),
      .busy (div_busy_r), .quotient (q_r)
   );
   bb3_div u_div_g (
      .clock (clock), .reset (reset), .start (state_ff == ST_LOAD),
      .numer ({sum_g_ff, 1'b0} + {9'd0, cnt_ff}), .denom (denom),
      .busy (div_busy_g), .quotient (q_g)
   );
   bb3_div u_div_b (
      .clock (clock), .reset (reset), .start (state_ff == ST_LOAD),
      .numer ({sum_b_ff, 1'b0} + {9'd0, cnt_ff}), .denom (denom),
      .busy (div_busy_b), .quotient (q_b)
   );

   // Output register; a result leaves on a transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (load) begin
         rsp_r_ff    <= q_r[7:0];
         rsp_g_ff    <= q_g[7:0];
         rsp_b_ff    <= q_b[7:0];
         rsp_last_ff <= last_ff;
      end
   end

   assign req_ready      = (state_ff == ST_IDLE) && !div_busy_g && !div_busy_b;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_red    = rsp_r_ff;
   assign rsp_out_green  = rsp_g_ff;
   assign rsp_out_blue   = rsp_b_ff;
   assign rsp_frame_last = rsp_last_ff;
endmodule
`default_nettype wire

/* sv/bb3_checker.sv */
// Port-level checker of the 3x3 box blur, bound to the top level.
`default_nettype none
`include "box_blur_3x3_edge_clipped_defines.svh"
module bb3_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [7:0]  rsp_out_red,
   input wire logic        rsp_frame_last
);
   // A stalled result stays and holds its payload.
   `BB3_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_out_red) && $stable(rsp_frame_last))

   // A result never appears in the cycle right after an input transfer.
   `BB3_ASSERT_NEXT(a_no_fast_rsp, req_valid && req_ready, !$rose(rsp_valid))

   // A new result comes with the block ready for the next item.
   `BB3_ASSERT_NOW(a_ready_after_result, $rose(rsp_valid), req_ready)
endmodule

bind box_blur_3x3_edge_clipped bb3_checker u_bb3_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_out_red    (rsp_out_red),
   .rsp_frame_last (rsp_frame_last)
);
`default_nettype wire

/* dv/box_blur_3x3_edge_clipped_test.sv */
// Self-checking testbench of the streaming 3x3 box blur with clipped edges.
`timescale 1ns / 1ps
`default_nettype none
module box_blur_3x3_edge_clipped_test;
   import bb3_pkg::*;

   localparam int MAX_W = DEF_MAX_WIDTH;
   localparam bit CMD_PIXEL = 1'b0;
   localparam bit CMD_FLUSH = 1'b1;

   typedef struct {
      pixel_type px;
      bit        last;
   } blurred_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_command = 1'b0;
   logic [7:0]  req_in_red = 8'd0;
   logic [7:0]  req_in_green = 8'd0;
   logic [7:0]  req_in_blue = 8'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_out_red;
   logic [7:0]  rsp_out_green;
   logic [7:0]  rsp_out_blue;
   logic        rsp_frame_last;
   logic        csr_we = 1'b0;
   logic        csr_index = 1'b0;
   logic [15:0] csr_wdata = 16'd0;

   box_blur_3x3_edge_clipped dut (.*);

   // Predictor state: four row slots, stream position and geometry.
   pixel_type   row_slots [4][MAX_W];
   int unsigned col_pos = 0, row_pos = 0;
   int unsigned frame_w = 1, frame_h = 1;
   int unsigned reg_width = 1, reg_height = 1;

   blurred_type expected_pixels [$];
   int          error_count = 0;
   int          burst_left = 0;
   int          stream_items = 0;

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("FAIL box_blur_3x3_edge_clipped");
      $finish;
   end

   // Computes the blurred pixel, if any, that one accepted item produces.
   function automatic bit blur_step(bit cmd, pixel_type px, output blurred_type res);
      int unsigned total, q, o, r, c, cnt, sr, sg, sb;
      int          nr, nc;
      cnt = 0; sr = 0; sg = 0; sb = 0;
      res = '{px: '0, last: 1'b0};
      if (row_pos == 0 && col_pos == 0) begin
         frame_w = (reg_width == 0) ? 1 : (reg_width > MAX_W) ? MAX_W : reg_width;
         frame_h = (reg_height == 0) ? 1 : reg_height;
      end
      total = frame_w * frame_h;
      q = row_pos * frame_w + col_pos;
      if (q < total) begin
         if (cmd) return 1'b0;
         row_slots[row_pos % 4][col_pos] = px;
      end
      col_pos++;
      if (col_pos >= frame_w) begin
         col_pos = 0;
         row_pos++;
      end
      if (q < frame_w + 1) return 1'b0;
      o = q - frame_w - 1;
      r = o / frame_w;
      c = o % frame_w;
      for (int dr = -1; dr <= 1; dr++) begin
         for (int dc = -1; dc <= 1; dc++) begin
            nr = int'(r) + dr;
            nc = int'(c) + dc;
            if (nr < 0 || nr >= int'(frame_h) || nc < 0 || nc >= int'(frame_w)) continue;
            sr += row_slots[nr % 4][nc].red;
            sg += row_slots[nr % 4][nc].green;
            sb += row_slots[nr % 4][nc].blue;
            cnt++;
         end
      end
      res.px.red   = 8'((2 * sr + cnt) / (2 * cnt));
      res.px.green = 8'((2 * sg + cnt) / (2 * cnt));
      res.px.blue  = 8'((2 * sb + cnt) / (2 * cnt));
      if (o + 1 >= total) begin
         res.last = 1'b1;
         row_pos = 0;
         col_pos = 0;
      end
      return 1'b1;
   endfunction

   // Register write; only called while the block is idle.
   task automatic write_reg(logic idx, logic [15:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_IMAGE_WIDTH) reg_width = val & 16'h0FFF;
      else reg_height = val;
      @(posedge clock);
   endtask

   // Sends one item in bursts with random gaps, and predicts at its transfer.
   task automatic send_item(bit cmd, pixel_type px);
      int          gap;
      blurred_type res;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_command <= cmd;
      req_in_red <= px.red;
      req_in_green <= px.green;
      req_in_blue <= px.blue;
      do @(posedge clock); while (!req_ready);
      stream_items++;
      if (blur_step(cmd, px, res)) expected_pixels.push_back(res);
   endtask

   // Lowers valid and waits until every expected pixel has arrived.
   task automatic drain;
      req_valid <= 1'b0;
      burst_left = 0;
      wait (expected_pixels.size() == 0);
      repeat (40) @(posedge clock);
   endtask

   function automatic pixel_type rand_pixel();
      return pixel_type'($urandom_range(0, 24'hFFFFFF));
   endfunction

   // One frame: pixels, optional early flushes as noise, then the drain items.
   task automatic run_frame(int w, int h, bit noisy, bit late_pixels);
      int eff_w;
      eff_w = (w == 0) ? 1 : (w > MAX_W) ? MAX_W : w;
      if (h == 0) h = 1;
      for (int i = 0; i < eff_w * h; i++) begin
         if (noisy && $urandom_range(0, 9) == 0) send_item(CMD_FLUSH, rand_pixel());
         send_item(CMD_PIXEL, rand_pixel());
      end
      for (int i = 0; i <= eff_w; i++)
         send_item((late_pixels && $urandom_range(0, 1)) ? CMD_PIXEL : CMD_FLUSH,
                   rand_pixel());
   endtask

   task automatic test_reset_geometry;
      send_item(CMD_PIXEL, pixel_type'(24'h123456));
      send_item(CMD_FLUSH, '0);
      send_item(CMD_FLUSH, '0);
      drain();
   endtask

   task automatic test_extreme_values;
      write_reg(CSR_IMAGE_WIDTH, 16'd3);
      write_reg(CSR_IMAGE_HEIGHT, 16'd3);
      for (int i = 0; i < 9; i++)
         send_item(CMD_PIXEL, (i % 2) ? pixel_type'(24'hFFFFFF) : pixel_type'(24'h000000));
      for (int i = 0; i < 4; i++) send_item(CMD_FLUSH, '1);
      drain();
   endtask

   task automatic test_zero_geometry;
      write_reg(CSR_IMAGE_WIDTH, 16'd0);
      write_reg(CSR_IMAGE_HEIGHT, 16'd0);
      run_frame(0, 0, 1'b0, 1'b0);
      drain();
   endtask

   // Early flush items are ignored; pixels past the frame act as flushes.
   task automatic test_early_flush_late_pixel;
      write_reg(CSR_IMAGE_WIDTH, 16'd2);
      write_reg(CSR_IMAGE_HEIGHT, 16'd2);
      send_item(CMD_FLUSH, rand_pixel());
      send_item(CMD_PIXEL, rand_pixel());
      send_item(CMD_FLUSH, rand_pixel());
      for (int i = 0; i < 3; i++) send_item(CMD_PIXEL, rand_pixel());
      for (int i = 0; i < 3; i++) send_item(CMD_PIXEL, rand_pixel());
      drain();
   endtask

   // Upper bits of a width write are dropped; tallest height is written, then replaced.
   task automatic test_width_mask;
      write_reg(CSR_IMAGE_HEIGHT, 16'hFFFF);
      write_reg(CSR_IMAGE_WIDTH, 16'hF003);
      write_reg(CSR_IMAGE_HEIGHT, 16'd2);
      run_frame(3, 2, 1'b0, 1'b0);
      drain();
   endtask

   // The sender holds off until all results are in, in the middle of a frame.
   task automatic test_sender_pause;
      write_reg(CSR_IMAGE_WIDTH, 16'd4);
      write_reg(CSR_IMAGE_HEIGHT, 16'd3);
      for (int i = 0; i < 8; i++) send_item(CMD_PIXEL, rand_pixel());
      req_valid <= 1'b0;
      burst_left = 0;
      wait (expected_pixels.size() == 0);
      @(posedge clock);
      for (int i = 0; i < 4; i++) send_item(CMD_PIXEL, rand_pixel());
      for (int i = 0; i < 5; i++) send_item(CMD_FLUSH, rand_pixel());
      drain();
   endtask

   task automatic test_random_frames;
      int w, h, start;
      start = stream_items;
      while (stream_items - start < 440) begin
         w = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
         h = $urandom_range(1, 6);
         write_reg(CSR_IMAGE_WIDTH, 16'(w));
         write_reg(CSR_IMAGE_HEIGHT, 16'(h));
         run_frame(w, h, $urandom_range(0, 3) == 0, $urandom_range(0, 2) == 0);
         drain();
      end
   endtask

   // Receiver stalls with a pattern that steps through four modes.
   int unsigned stall_tick = 0;
   always @(posedge clock) begin
      stall_tick <= stall_tick + 1;
      case ((stall_tick / 53) % 4)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= $urandom_range(0, 1);
         2: rsp_ready <= ((stall_tick % 5) == 0);
         default: rsp_ready <= ($urandom_range(0, 7) != 0);
      endcase
   end

   // Compares each result transfer with the oldest expected pixel.
   always @(posedge clock) begin
      blurred_type exp_px;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_pixels.size() == 0) begin
            $display("%0t unexpected result %h last %b", $time,
                     {rsp_out_red, rsp_out_green, rsp_out_blue}, rsp_frame_last);
            error_count++;
         end else begin
            exp_px = expected_pixels.pop_front();
            if (rsp_out_red !== exp_px.px.red) begin
               $display("%0t red expected %h actual %h", $time, exp_px.px.red, rsp_out_red);
               error_count++;
            end
            if (rsp_out_green !== exp_px.px.green) begin
               $display("%0t green expected %h actual %h", $time, exp_px.px.green,
                        rsp_out_green);
               error_count++;
            end
            if (rsp_out_blue !== exp_px.px.blue) begin
               $display("%0t blue expected %h actual %h", $time, exp_px.px.blue,
                        rsp_out_blue);
               error_count++;
            end
            if (rsp_frame_last !== exp_px.last) begin
               $display("%0t frame_last expected %b actual %b", $time, exp_px.last,
                        rsp_frame_last);
               error_count++;
            end
         end
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_geometry();
      test_extreme_values();
      test_zero_geometry();
      test_early_flush_late_pixel();
      test_sender_pause();
      test_width_mask();
      test_random_frames();
      if (expected_pixels.size() != 0) error_count++;
      if (error_count == 0) begin
         $display("PASS box_blur_3x3_edge_clipped");
      end else begin
         $display("FAIL box_blur_3x3_edge_clipped");
      end
      $finish;
   end
endmodule
`default_nettype wire
